### design/lobm_pkg.sv
// Package for the limit order book matcher: sizes, result kinds, beat type.
// No dependencies.
package lobm_pkg;
   localparam int SIDE_SLOTS = 32;
   localparam int SLOT_W = $clog2(SIDE_SLOTS);

   localparam logic [1:0] KIND_RECEIVE = 2'd0;
   localparam logic [1:0] KIND_MATCH   = 2'd1;
   localparam logic [1:0] KIND_REJECT  = 2'd2;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [31:0] received_id;
      logic        received_side;
      logic [31:0] received_price;
      logic [31:0] buyer_id;
      logic [31:0] seller_id;
      logic [31:0] units;
      logic        last_result;
   } beat_type;

   typedef struct packed {
      logic [31:0] price;
      logic [31:0] owner;
      logic [31:0] remaining;
      logic [31:0] stamp;
   } entry_type;
endpackage

### design/limit_order_book_matcher.sv
// Top level of the limit order book matcher: sequencer, per-side entry memories.
// Depends on lobm_pkg.
//
//   channel  dir  ports
//   req      in   req_valid/req_ready, ident side quantity price
//   rsp      out  rsp_valid/rsp_ready, result fields, last_result
//
// An order rests or is rejected on acceptance, then each match attempt scans both
// memories one slot a cycle, as one read port per side allows no more.
// Up to SIDE_SLOTS matches follow an order.
// A beat is held during the scan until it is known whether it is the final one.
// Reset clears occupancy bits and the arrival counter; no clearing pass.
// A stalled rsp beat holds the sequencer in place.
module limit_order_book_matcher (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [31:0] req_ident,
   input  logic req_side,
   input  logic [31:0] req_quantity,
   input  logic [31:0] req_price,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [1:0] rsp_result_kind,
   output logic [31:0] rsp_received_id,
   output logic rsp_received_side,
   output logic [31:0] rsp_received_price,
   output logic [31:0] rsp_buyer_id,
   output logic [31:0] rsp_seller_id,
   output logic [31:0] rsp_units,
   output logic rsp_last_result
);
   import lobm_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_EVAL = 5'b00100,
      ST_EMIT = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   entry_type bid_mem [SIDE_SLOTS];
   entry_type ask_mem [SIDE_SLOTS];
   entry_type bid_rd_ff, ask_rd_ff;
   logic [SIDE_SLOTS-1:0] bid_occ_ff, bid_occ_in, ask_occ_ff, ask_occ_in;
   logic [31:0] arrival_ff, arrival_in;
   logic [SLOT_W:0] scan_ff, scan_in;
   logic [SLOT_W-1:0] rd_addr;
   logic [SLOT_W-1:0] rd_slot_ff;
   logic rd_vld_ff;
   logic [SLOT_W-1:0] bbest_ff, bbest_in, abest_ff, abest_in;
   logic bfound_ff, bfound_in, afound_ff, afound_in;
   entry_type bbe_ff, bbe_in, abe_ff, abe_in;
   beat_type out_ff, out_in;
   logic out_vld_ff, out_vld_in;
   logic [SLOT_W:0] nmatch_ff, nmatch_in;
   logic bwr, awr;
   logic [SLOT_W-1:0] bwa, awa;
   entry_type bwd, awd;
   logic [SLOT_W-1:0] free_slot;
   logic free_any;
   logic [31:0] mq;

   always_comb begin
      free_any = 1'b0;
      free_slot = '0;
      for (int i = SIDE_SLOTS - 1; i >= 0; i--) begin
         if (!(req_side ? ask_occ_ff[i] : bid_occ_ff[i])) begin
            free_any = 1'b1;
            free_slot = SLOT_W'(i);
         end
      end
   end

   assign rd_addr = scan_ff[SLOT_W-1:0];
   assign req_ready = (state_ff == ST_IDLE) && !out_vld_ff;
   assign mq = (bbe_ff.remaining < abe_ff.remaining) ? bbe_ff.remaining : abe_ff.remaining;

   always_ff @(posedge clock) begin
      if (bwr) bid_mem[bwa] <= bwd;
      if (awr) ask_mem[awa] <= awd;
      bid_rd_ff <= bid_mem[rd_addr];
      ask_rd_ff <= ask_mem[rd_addr];
      rd_slot_ff <= rd_addr;
   end

   always_comb begin
      state_in = state_ff;
      bid_occ_in = bid_occ_ff;
      ask_occ_in = ask_occ_ff;
      arrival_in = arrival_ff;
      scan_in = scan_ff;
      bbest_in = bbest_ff; abest_in = abest_ff;
      bfound_in = bfound_ff; afound_in = afound_ff;
      bbe_in = bbe_ff; abe_in = abe_ff;
      out_in = out_ff;
      out_vld_in = out_vld_ff && !(rsp_valid && rsp_ready);
      nmatch_in = nmatch_ff;
      bwr = 1'b0; awr = 1'b0;
      bwa = '0; awa = '0;
      bwd = '{price: req_price, owner: req_ident, remaining: req_quantity,
              stamp: arrival_ff};
      awd = bwd;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               out_in = '0;
               out_in.received_id = req_ident;
               out_in.received_side = req_side;
               out_in.received_price = req_price;
               out_in.units = req_quantity;
               out_vld_in = 1'b1;
               if (!free_any) begin
                  out_in.result_kind = KIND_REJECT;
                  out_in.last_result = 1'b1;
               end else begin
                  out_in.result_kind = KIND_RECEIVE;
                  if (req_side) begin
                     awr = 1'b1; awa = free_slot; ask_occ_in[free_slot] = 1'b1;
                  end else begin
                     bwr = 1'b1; bwa = free_slot; bid_occ_in[free_slot] = 1'b1;
                  end
                  arrival_in = arrival_ff + 32'd1;
                  nmatch_in = '0;
                  scan_in = '0;
                  bfound_in = 1'b0; afound_in = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_vld_ff) begin
               if (bid_occ_ff[rd_slot_ff]) begin
                  if (!bfound_ff || bid_rd_ff.price > bbe_ff.price ||
                      (bid_rd_ff.price == bbe_ff.price &&
                       (arrival_ff - bid_rd_ff.stamp) > (arrival_ff - bbe_ff.stamp))) begin
                     bfound_in = 1'b1; bbest_in = rd_slot_ff; bbe_in = bid_rd_ff;
                  end
               end
               if (ask_occ_ff[rd_slot_ff]) begin
                  if (!afound_ff || ask_rd_ff.price < abe_ff.price ||
                      (ask_rd_ff.price == abe_ff.price &&
                       (arrival_ff - ask_rd_ff.stamp) > (arrival_ff - abe_ff.stamp))) begin
                     afound_in = 1'b1; abest_in = rd_slot_ff; abe_in = ask_rd_ff;
                  end
               end
            end
            if (scan_ff == (SLOT_W+1)'(SIDE_SLOTS)) begin
               state_in = ST_EVAL;
            end else begin
               scan_in = scan_ff + (SLOT_W+1)'(1);
            end
         end
         ST_EVAL: begin
            if (bfound_ff && afound_ff && bbe_ff.price >= abe_ff.price &&
                nmatch_ff != (SLOT_W+1)'(SIDE_SLOTS)) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_EMIT: begin
            if (!out_vld_ff || rsp_ready) begin
               out_in = '0;
               out_in.result_kind = KIND_MATCH;
               out_in.buyer_id = bbe_ff.owner;
               out_in.seller_id = abe_ff.owner;
               out_in.units = mq;
               out_vld_in = 1'b1;
               nmatch_in = nmatch_ff + (SLOT_W+1)'(1);
               if (bbe_ff.remaining > abe_ff.remaining) begin
                  bwr = 1'b1; bwa = bbest_ff; bwd = bbe_ff;
                  bwd.remaining = bbe_ff.remaining - abe_ff.remaining;
                  ask_occ_in[abest_ff] = 1'b0;
               end else if (bbe_ff.remaining < abe_ff.remaining) begin
                  awr = 1'b1; awa = abest_ff; awd = abe_ff;
                  awd.remaining = abe_ff.remaining - bbe_ff.remaining;
                  bid_occ_in[bbest_ff] = 1'b0;
               end else begin
                  bid_occ_in[bbest_ff] = 1'b0;
                  ask_occ_in[abest_ff] = 1'b0;
               end
               scan_in = '0;
               bfound_in = 1'b0; afound_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_DONE: begin
            // mark the beat held in the output register as final
            out_in.last_result = 1'b1;
            out_vld_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bid_occ_ff <= '0;
         ask_occ_ff <= '0;
         arrival_ff <= '0;
         out_vld_ff <= 1'b0;
         rd_vld_ff <= 1'b0;
         scan_ff <= '0;
         nmatch_ff <= '0;
         bfound_ff <= 1'b0;
         afound_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bid_occ_ff <= bid_occ_in;
         ask_occ_ff <= ask_occ_in;
         arrival_ff <= arrival_in;
         out_vld_ff <= out_vld_in;
         rd_vld_ff <= (state_ff == ST_SCAN) && (scan_ff != (SLOT_W+1)'(SIDE_SLOTS));
         scan_ff <= scan_in;
         nmatch_ff <= nmatch_in;
         bfound_ff <= bfound_in;
         afound_ff <= afound_in;
      end
   end

   always_ff @(posedge clock) begin
      bbest_ff <= bbest_in; abest_ff <= abest_in;
      bbe_ff <= bbe_in; abe_ff <= abe_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_vld_ff && ((state_ff == ST_IDLE) || (state_ff == ST_EMIT));
   assign rsp_result_kind = out_ff.result_kind;
   assign rsp_received_id = out_ff.received_id;
   assign rsp_received_side = out_ff.received_side;
   assign rsp_received_price = out_ff.received_price;
   assign rsp_buyer_id = out_ff.buyer_id;
   assign rsp_seller_id = out_ff.seller_id;
   assign rsp_units = out_ff.units;
   assign rsp_last_result = out_ff.last_result;

`ifndef SYNTH
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("request taken while busy");
   a_match_both: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (bfound_ff && afound_ff))
      else $error("match without both sides");
   a_bound: assert property (@(posedge clock) disable iff (reset)
      nmatch_ff <= (SLOT_W+1)'(SIDE_SLOTS))
      else $error("match count overrun");
`endif
endmodule
